// ===== hw/rtl/eprs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EEPROM page read splitter package
// Shared sizes, status codes, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package eprs_pkg;

    // Memory geometry. PAGE_BYTES must be a power of two.
    localparam int MEM_BYTES   = 4096;
    localparam int PAGE_BYTES  = 64;
    localparam int MAX_RESULTS = 64;

    localparam int ADDR_W    = 16;
    localparam int END_W     = ADDR_W + 1;
    localparam int LEN_W     = 9;
    localparam int CTRL_W    = 8;
    localparam int PAGE_BITS = $clog2(PAGE_BYTES);
    localparam int PAGE_NUM_W = END_W - PAGE_BITS + 1;

    localparam logic [END_W-1:0] MEM_END   = END_W'(MEM_BYTES);
    localparam logic [END_W-1:0] PAGE_MASK = END_W'(PAGE_BYTES - 1);
    localparam logic [PAGE_NUM_W-1:0] MAX_PAGES = PAGE_NUM_W'(MAX_RESULTS);
    localparam logic [CTRL_W-1:0] DEV_BYTE_RESET = 8'd160;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ZERO  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    emit_err;
        logic    emit_chunk;
        t_status err_code;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic zero_len;
        logic out_of_range;
        logic chunk_last;
    } t_stat;

endpackage

// ===== hw/rtl/eeprom_page_read_splitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EEPROM page read splitter
// Splits one read request for a paged EEPROM into chunks that never cross a
// page, or gives one error result for an empty or out-of-range request.
//
//   Channel   Handshake                      Payload
//   request   start && !busy                 i_start_address, i_byte_count
//   result    o_result_valid (one cycle)     o_status .. o_last
//   config    i_cfg_we                       i_cfg_wdata (device write byte)
//
// A request is handled in order: a load step, a check step, then one chunk
// per cycle for each page touched (an error result is formed in the check step).
// The chunk walker emits one chunk per cycle.
// Each result appears in the cycle after it is formed, in the output register.
// Reset is synchronous and active low; the device byte resets to 160.
// The receiver cannot stall; results are never held back.
// ----------------------------------------------------------------------------
module eeprom_page_read_splitter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [eprs_pkg::CTRL_W-1:0] i_cfg_wdata,
    input  logic                        start,
    output logic                        busy,
    input  logic [eprs_pkg::ADDR_W-1:0] i_start_address,
    input  logic [eprs_pkg::ADDR_W-1:0] i_byte_count,
    output logic                        o_result_valid,
    output logic [1:0]                  o_status,
    output logic [eprs_pkg::ADDR_W-1:0] o_chunk_address,
    output logic [eprs_pkg::ADDR_W-1:0] o_buffer_offset,
    output logic [eprs_pkg::LEN_W-1:0]  o_chunk_length,
    output logic                        o_single_byte,
    output logic [eprs_pkg::CTRL_W-1:0] o_write_control,
    output logic [eprs_pkg::CTRL_W-1:0] o_read_control,
    output logic                        o_last
);
    import eprs_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // Controller.
    eprs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .busy    (busy)
    );

    // Datapath.
    eprs_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_start_address (i_start_address),
        .i_byte_count    (i_byte_count),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_result_valid  (o_result_valid),
        .o_status        (o_status),
        .o_chunk_address (o_chunk_address),
        .o_buffer_offset (o_buffer_offset),
        .o_chunk_length  (o_chunk_length),
        .o_single_byte   (o_single_byte),
        .o_write_control (o_write_control),
        .o_read_control  (o_read_control),
        .o_last          (o_last)
    );

    // An accepted request makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an accepted request");

    // Chunks of one request follow each other with no gap.
    a_chunks_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_last |=> o_result_valid)
        else $error("gap inside a chunk sequence");

    // Error results always close the request.
    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_status != ST_OK) |-> o_last)
        else $error("error result without last");

    // Consecutive chunks are contiguous in memory.
    a_chunks_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_last |=>
        o_chunk_address == $past(o_chunk_address) + ADDR_W'($past(o_chunk_length)))
        else $error("chunk address does not follow previous chunk");

endmodule

// ===== hw/rtl/eprs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EEPROM page read splitter controller
// Sequences one request: load, check, then an error or one chunk per cycle.
// ----------------------------------------------------------------------------
module eprs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  eprs_pkg::t_stat i_stat,
    output eprs_pkg::t_cmd  o_cmd,
    output logic           busy
);
    import eprs_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state         = r_state;
        o_cmd.load      = 1'b0;
        o_cmd.emit_err  = 1'b0;
        o_cmd.emit_chunk = 1'b0;
        o_cmd.err_code  = ST_ZERO;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.zero_len) begin
                    o_cmd.emit_err = 1'b1;
                    o_cmd.err_code = ST_ZERO;
                    n_state        = S_IDLE;
                end else if (i_stat.out_of_range) begin
                    o_cmd.emit_err = 1'b1;
                    o_cmd.err_code = ST_RANGE;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit_chunk = 1'b1;
                if (i_stat.chunk_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

// ===== hw/rtl/eprs_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EEPROM page read splitter datapath
// Holds the request, the device byte register, the chunk walker and the
// registered result ports.
// ----------------------------------------------------------------------------
module eprs_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [eprs_pkg::CTRL_W-1:0]   i_cfg_wdata,
    input  logic [eprs_pkg::ADDR_W-1:0]   i_start_address,
    input  logic [eprs_pkg::ADDR_W-1:0]   i_byte_count,
    input  eprs_pkg::t_cmd                i_cmd,
    output eprs_pkg::t_stat               o_stat,
    output logic                          o_result_valid,
    output logic [1:0]                    o_status,
    output logic [eprs_pkg::ADDR_W-1:0]   o_chunk_address,
    output logic [eprs_pkg::ADDR_W-1:0]   o_buffer_offset,
    output logic [eprs_pkg::LEN_W-1:0]    o_chunk_length,
    output logic                          o_single_byte,
    output logic [eprs_pkg::CTRL_W-1:0]   o_write_control,
    output logic [eprs_pkg::CTRL_W-1:0]   o_read_control,
    output logic                          o_last
);
    import eprs_pkg::*;

    logic [CTRL_W-1:0] r_dev_byte;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_offs;
    logic [END_W-1:0]  r_end;
    logic              r_zero;

    logic [END_W-1:0]      w_addr_ext;
    logic [END_W-1:0]      w_end_m1;
    logic [PAGE_NUM_W-1:0] w_first_page;
    logic [PAGE_NUM_W-1:0] w_last_page;
    logic [PAGE_NUM_W-1:0] w_pages;
    logic [END_W-1:0]      w_page_end;
    logic [END_W-1:0]      w_stop;
    logic [END_W-1:0]      w_len;
    logic [LEN_W-1:0]      n_len;

    logic                  r_valid;
    logic [1:0]            r_status;
    logic [ADDR_W-1:0]     r_o_addr;
    logic [ADDR_W-1:0]     r_o_offs;
    logic [LEN_W-1:0]      r_o_len;
    logic                  r_o_single;
    logic [CTRL_W-1:0]     r_o_wc;
    logic [CTRL_W-1:0]     r_o_rc;
    logic                  r_o_last;

    // Device byte register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_byte <= DEV_BYTE_RESET;
        end else if (i_cfg_we) begin
            r_dev_byte <= i_cfg_wdata;
        end
    end

    // Range and page-count checks on the held request.
    assign w_addr_ext   = {1'b0, r_addr};
    assign w_end_m1     = r_end - END_W'(1);
    assign w_first_page = PAGE_NUM_W'(w_addr_ext >> PAGE_BITS);
    assign w_last_page  = PAGE_NUM_W'(w_end_m1 >> PAGE_BITS);
    assign w_pages      = w_last_page - w_first_page + PAGE_NUM_W'(1);

    assign o_stat.zero_len     = r_zero;
    assign o_stat.out_of_range = (r_end > MEM_END) || (w_pages > MAX_PAGES);

    // Current chunk: up to the next page boundary or the request end.
    assign w_page_end        = (w_addr_ext | PAGE_MASK) + END_W'(1);
    assign w_stop            = (w_page_end < r_end) ? w_page_end : r_end;
    assign w_len             = w_stop - w_addr_ext;
    assign n_len             = w_len[LEN_W-1:0];
    assign o_stat.chunk_last = (w_stop == r_end);

    // Request and walker registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr <= i_start_address;
            r_offs <= '0;
            r_end  <= {1'b0, i_start_address} + {1'b0, i_byte_count};
            r_zero <= (i_byte_count == '0);
        end else if (i_cmd.emit_chunk) begin
            r_addr <= w_stop[ADDR_W-1:0];
            r_offs <= r_offs + ADDR_W'(n_len);
        end
    end

    // Result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit_err || i_cmd.emit_chunk;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_chunk) begin
            r_status   <= ST_OK;
            r_o_addr   <= r_addr;
            r_o_offs   <= r_offs;
            r_o_len    <= n_len;
            r_o_single <= (n_len == LEN_W'(1));
            r_o_wc     <= r_dev_byte;
            r_o_rc     <= r_dev_byte | CTRL_W'(1);
            r_o_last   <= o_stat.chunk_last;
        end else if (i_cmd.emit_err) begin
            r_status   <= i_cmd.err_code;
            r_o_addr   <= '0;
            r_o_offs   <= '0;
            r_o_len    <= '0;
            r_o_single <= 1'b0;
            r_o_wc     <= '0;
            r_o_rc     <= '0;
            r_o_last   <= 1'b1;
        end
    end

    assign o_result_valid  = r_valid;
    assign o_status        = r_status;
    assign o_chunk_address = r_o_addr;
    assign o_buffer_offset = r_o_offs;
    assign o_chunk_length  = r_o_len;
    assign o_single_byte   = r_o_single;
    assign o_write_control = r_o_wc;
    assign o_read_control  = r_o_rc;
    assign o_last          = r_o_last;

endmodule
